// ===== src/lsh_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lsh_pkg
// Types and codes shared by the lockstep start-up handshake block.
// ----------------------------------------------------------------------------
package lsh_pkg;

   localparam int SLOT_W    = 3;
   localparam int NUM_SLOTS = 1 << SLOT_W;
   localparam int LEN_W     = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 8;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IS_HOST    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOCAL_SLOT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PART_MASK  = 2'd2;

   // input action codes
   localparam logic [1:0] ACT_LOAD = 2'd0;
   localparam logic [1:0] ACT_POLL = 2'd1;
   localparam logic [1:0] ACT_MSG  = 2'd2;

   // received message kinds
   localparam logic [2:0] KIND_LOAD_ERR   = 3'd0;
   localparam logic [2:0] KIND_START_COND = 3'd1;
   localparam logic [2:0] KIND_LOADED     = 3'd2;
   localparam logic [2:0] KIND_ACTIONS    = 3'd3;
   localparam logic [2:0] KIND_OTHER      = 3'd4;

   // outgoing message kinds
   localparam logic [1:0] SEND_START_COND = 2'd0;
   localparam logic [1:0] SEND_LOADED     = 2'd1;
   localparam logic [1:0] SEND_LOAD_ERR   = 2'd2;
   localparam logic [1:0] SEND_PLAY_ERR   = 2'd3;

   typedef enum logic [3:0] {
      PH_START       = 4'd0,
      PH_HOST_ARGS   = 4'd1,
      PH_CLIENT_WAIT = 4'd2,
      PH_LOADING     = 4'd3,
      PH_LOADED      = 4'd4,
      PH_LISTEN      = 4'd5,
      PH_PLAYING     = 4'd6,
      PH_FINISHED    = 4'd7,
      PH_LOAD_ERR    = 4'd8,
      PH_PLAY_ERR    = 4'd9
   } phase_type;

   typedef struct packed {
      logic [1:0]       action;
      logic             load_ok;
      logic [2:0]       msg_kind;
      logic [SLOT_W-1:0] sender;
      logic [LEN_W-1:0] msg_len;
   } req_type;

   typedef struct packed {
      logic       send_valid;
      logic [1:0] send_kind;
      logic       game_frame_request;
      logic       load_attempted;
      logic       args_accepted;
      logic       forward_actions;
      logic       unknown_sender;
      logic [3:0] phase;
      logic       in_error;
   } rsp_type;

   typedef struct packed {
      logic              is_host;
      logic [SLOT_W-1:0] local_slot;
      logic [NUM_SLOTS-1:0] participant_mask;
   } cfg_type;

   // slots at or above the participant limit never take part
   function automatic logic [NUM_SLOTS-1:0] slot_limit(input int max_slots);
      logic [NUM_SLOTS-1:0] m;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         m[i] = (i < max_slots);
      end
      return m;
   endfunction

endpackage
`default_nettype wire

// ===== src/lsh_csr.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lsh_csr
// Configuration registers: host mode, own slot and participant mask.
// ----------------------------------------------------------------------------
module lsh_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [lsh_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [lsh_pkg::CSR_DAT_W-1:0] csr_wdata,
   output lsh_pkg::cfg_type                   cfg
);

   lsh_pkg::cfg_type cfg_ff, cfg_in;
   logic             wr;

   assign csr_ready = 1'b1;
   assign wr        = csr_valid && csr_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (csr_index)
            lsh_pkg::CSR_IS_HOST:    cfg_in.is_host = csr_wdata[0];
            lsh_pkg::CSR_LOCAL_SLOT: cfg_in.local_slot = csr_wdata[lsh_pkg::SLOT_W-1:0];
            lsh_pkg::CSR_PART_MASK:  cfg_in.participant_mask = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// ===== src/lsh_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lsh_core
// Handshake state machine and loaded flags; computes one result per item.
// ----------------------------------------------------------------------------
module lsh_core #(
   parameter int MAX_PARTICIPANTS = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step,
   input  wire lsh_pkg::req_type item,
   input  wire lsh_pkg::cfg_type cfg,
   output lsh_pkg::rsp_type      result
);

   localparam logic [lsh_pkg::NUM_SLOTS-1:0] SLOT_LIMIT =
      lsh_pkg::slot_limit(MAX_PARTICIPANTS);

   lsh_pkg::phase_type              phase_ff, phase_in;
   logic [lsh_pkg::NUM_SLOTS-1:0]   flags_ff, flags_in;
   logic [lsh_pkg::NUM_SLOTS-1:0]   active;
   logic [lsh_pkg::NUM_SLOTS-1:0]   sender_bit;
   logic [lsh_pkg::NUM_SLOTS-1:0]   flags_set;
   lsh_pkg::phase_type              phase_nx;
   logic [lsh_pkg::NUM_SLOTS-1:0]   flags_nx;

   assign active     = cfg.participant_mask & SLOT_LIMIT;
   assign sender_bit = lsh_pkg::NUM_SLOTS'(1) << item.sender;
   assign flags_set  = flags_ff | sender_bit;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= lsh_pkg::PH_START;
         flags_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         flags_ff <= flags_in;
      end
   end

   always_comb begin
      phase_nx = phase_ff;
      flags_nx = flags_ff;
      result   = '0;
      case (item.action)
         lsh_pkg::ACT_LOAD: begin
            if (phase_ff == lsh_pkg::PH_START) begin
               result.load_attempted = 1'b1;
               if (item.load_ok) phase_nx = lsh_pkg::PH_PLAYING;
            end
         end
         lsh_pkg::ACT_POLL: begin
            case (phase_ff)
               lsh_pkg::PH_PLAYING: result.game_frame_request = 1'b1;
               lsh_pkg::PH_START: begin
                  phase_nx = cfg.is_host ? lsh_pkg::PH_HOST_ARGS : lsh_pkg::PH_CLIENT_WAIT;
               end
               lsh_pkg::PH_HOST_ARGS: begin
                  result.send_valid = 1'b1;
                  result.send_kind  = lsh_pkg::SEND_START_COND;
                  phase_nx          = lsh_pkg::PH_LOADING;
               end
               lsh_pkg::PH_LOADING: begin
                  result.load_attempted = 1'b1;
                  phase_nx = item.load_ok ? lsh_pkg::PH_LOADED : lsh_pkg::PH_LOAD_ERR;
               end
               lsh_pkg::PH_LOADED: begin
                  result.send_valid = 1'b1;
                  result.send_kind  = lsh_pkg::SEND_LOADED;
                  phase_nx          = lsh_pkg::PH_LISTEN;
               end
               lsh_pkg::PH_LOAD_ERR: begin
                  result.send_valid = 1'b1;
                  result.send_kind  = lsh_pkg::SEND_LOAD_ERR;
               end
               lsh_pkg::PH_PLAY_ERR: begin
                  result.send_valid = 1'b1;
                  result.send_kind  = lsh_pkg::SEND_PLAY_ERR;
               end
               default: ;
            endcase
         end
         lsh_pkg::ACT_MSG: begin
            // empty messages are dropped
            if (item.msg_len != '0) begin
               case (item.msg_kind)
                  lsh_pkg::KIND_START_COND: begin
                     if (item.sender != cfg.local_slot &&
                         phase_ff == lsh_pkg::PH_CLIENT_WAIT) begin
                        result.args_accepted = 1'b1;
                        phase_nx             = lsh_pkg::PH_LOADING;
                     end
                  end
                  lsh_pkg::KIND_LOADED: begin
                     // once all are loaded, further announcements are ignored
                     if ((flags_ff & active) != active) begin
                        if ((active & sender_bit) != '0) begin
                           flags_nx = flags_set;
                        end else begin
                           result.unknown_sender = 1'b1;
                        end
                        if ((flags_nx & active) == active) phase_nx = lsh_pkg::PH_PLAYING;
                     end
                  end
                  lsh_pkg::KIND_ACTIONS: begin
                     if (phase_ff == lsh_pkg::PH_PLAYING && item.msg_len > 16'd1) begin
                        result.forward_actions = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         default: ;
      endcase
      result.phase    = phase_nx;
      result.in_error = (phase_nx == lsh_pkg::PH_LOAD_ERR) ||
                        (phase_nx == lsh_pkg::PH_PLAY_ERR);
      phase_in = step ? phase_nx : phase_ff;
      flags_in = step ? flags_nx : flags_ff;
   end

endmodule
`default_nettype wire

// ===== src/lockstep_startup_handshake_core.sv =====
`default_nettype none
// Path: an accepted transfer is held in the input register, then its result is
// written to the result register, from which the result transfer is made.
// Throughput: one item per cycle unless the result side stalls; the input and
// result registers run as a two-stage pipeline, taking the next item while a result waits.
// Reset (synchronous, active high) clears the phase, the loaded flags, the
// configuration registers and both valid flags.
// ----------------------------------------------------------------------------
// lockstep_startup_handshake_core
// Top level: input register, handshake core, result register and CSRs.
// ----------------------------------------------------------------------------
module lockstep_startup_handshake_core #(
   parameter int MAX_PARTICIPANTS = 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire lsh_pkg::req_type              req_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output lsh_pkg::rsp_type                   rsp_data,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [lsh_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [lsh_pkg::CSR_DAT_W-1:0] csr_wdata
);

   lsh_pkg::cfg_type cfg;
   lsh_pkg::rsp_type result;

   logic             in_valid_ff, in_valid_in;
   lsh_pkg::req_type in_data_ff, in_data_in;
   logic             out_valid_ff, out_valid_in;
   lsh_pkg::rsp_type out_data_ff, out_data_in;
   logic             advance, fire, take;

   lsh_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lsh_core #(
      .MAX_PARTICIPANTS (MAX_PARTICIPANTS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (fire),
      .item   (in_data_ff),
      .cfg    (cfg),
      .result (result)
   );

   // result register can load when empty or being drained
   assign advance   = !out_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign take      = req_valid && req_ready;

   always_comb begin
      in_valid_in  = take ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
      in_data_in   = take ? req_data : in_data_ff;
      out_valid_in = fire ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);
      out_data_in  = fire ? result : out_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

`ifndef ASSERT_OFF
   // a held item must not be lost while the result side is stalled
   a_hold_item: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_data_ff))
      else $error("input item dropped while stalled");

   // every item processed produces a visible result in the next cycle
   a_fire_result: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid)
      else $error("processed item left no result");

   a_kind_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.send_valid |-> rsp_data.send_kind == lsh_pkg::SEND_START_COND)
      else $error("send kind set without a send");

   a_forward_playing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.forward_actions |->
         rsp_data.phase == lsh_pkg::PH_PLAYING)
      else $error("actions forwarded outside playing");

   a_args_loading: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.args_accepted |-> rsp_data.phase == lsh_pkg::PH_LOADING)
      else $error("arguments taken without moving to loading");
`endif

endmodule
`default_nettype wire

// ===== bench/lsh_session_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lsh_session_checker
// Watches the register, request and result channels of the handshake core,
// keeps its own copy of the session state, predicts one result per request
// transfer and compares every result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module lsh_session_checker
   import lsh_pkg::*;
#(
   parameter int MAX_PARTICIPANTS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  req_type              req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  rsp_type              rsp_data,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata,
   output int                   fail_count,
   output int                   outstanding
);

   phase_type            phase_q;
   logic [NUM_SLOTS-1:0] loaded_q;
   logic                 host_q;
   logic [SLOT_W-1:0]    slot_q;
   logic [NUM_SLOTS-1:0] mask_q;
   rsp_type              outcome_q[$];
   int                   owed       = 0;
   int                   mismatches = 0;

   assign fail_count  = mismatches;
   assign outstanding = owed;

   // slots at or above the participant limit never count
   function automatic logic [NUM_SLOTS-1:0] live_mask();
      logic [NUM_SLOTS-1:0] m;
      m = mask_q;
      for (int i = MAX_PARTICIPANTS; i < NUM_SLOTS; i++) m[i] = 1'b0;
      return m;
   endfunction

   function automatic bit every_slot_loaded();
      return (loaded_q & live_mask()) == live_mask();
   endfunction

   function automatic rsp_type advance_session(input req_type r);
      rsp_type              o;
      logic [NUM_SLOTS-1:0] sender_bit;
      o          = '0;
      sender_bit = NUM_SLOTS'(1) << r.sender;
      case (r.action)
         ACT_LOAD: begin
            if (phase_q == PH_START) begin
               o.load_attempted = 1'b1;
               if (r.load_ok) phase_q = PH_PLAYING;
            end
         end
         ACT_POLL: begin
            case (phase_q)
               PH_PLAYING: o.game_frame_request = 1'b1;
               PH_START: phase_q = host_q ? PH_HOST_ARGS : PH_CLIENT_WAIT;
               PH_HOST_ARGS: begin
                  o.send_valid = 1'b1;
                  o.send_kind  = SEND_START_COND;
                  phase_q      = PH_LOADING;
               end
               PH_LOADING: begin
                  o.load_attempted = 1'b1;
                  phase_q          = r.load_ok ? PH_LOADED : PH_LOAD_ERR;
               end
               PH_LOADED: begin
                  o.send_valid = 1'b1;
                  o.send_kind  = SEND_LOADED;
                  phase_q      = PH_LISTEN;
               end
               PH_LOAD_ERR: begin
                  o.send_valid = 1'b1;
                  o.send_kind  = SEND_LOAD_ERR;
               end
               PH_PLAY_ERR: begin
                  o.send_valid = 1'b1;
                  o.send_kind  = SEND_PLAY_ERR;
               end
               default: ;
            endcase
         end
         ACT_MSG: begin
            // empty messages carry no kind byte and are dropped
            if (r.msg_len != '0) begin
               case (r.msg_kind)
                  KIND_START_COND: begin
                     if (r.sender != slot_q && phase_q == PH_CLIENT_WAIT) begin
                        o.args_accepted = 1'b1;
                        phase_q         = PH_LOADING;
                     end
                  end
                  KIND_LOADED: begin
                     if (!every_slot_loaded()) begin
                        if ((live_mask() & sender_bit) != '0) loaded_q = loaded_q | sender_bit;
                        else o.unknown_sender = 1'b1;
                        if (every_slot_loaded()) phase_q = PH_PLAYING;
                     end
                  end
                  KIND_ACTIONS: begin
                     if (phase_q == PH_PLAYING && r.msg_len > 16'd1) o.forward_actions = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         default: ;
      endcase
      o.phase    = phase_q;
      o.in_error = (phase_q == PH_LOAD_ERR) || (phase_q == PH_PLAY_ERR);
      return o;
   endfunction

   task automatic compare_field(input string label, input logic [15:0] want,
                                input logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h actual %0h", $time, label, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         phase_q  = PH_START;
         loaded_q = '0;
         host_q   = 1'b0;
         slot_q   = '0;
         mask_q   = '0;
         outcome_q.delete();
         owed = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_IS_HOST:    host_q = csr_wdata[0];
               CSR_LOCAL_SLOT: slot_q = csr_wdata[SLOT_W-1:0];
               CSR_PART_MASK:  mask_q = csr_wdata[NUM_SLOTS-1:0];
               default: ;
            endcase
         end
         // a result never leaves at the edge its request is taken
         if (rsp_valid && rsp_ready) begin
            if (owed == 0) begin
               $display("%0t: result expected none actual %h", $time, rsp_data);
               mismatches++;
            end else begin
               want = outcome_q.pop_front();
               owed--;
               compare_field("send_valid", 16'(want.send_valid),
                             16'(rsp_data.send_valid));
               compare_field("send_kind", 16'(want.send_kind), 16'(rsp_data.send_kind));
               compare_field("game_frame_request", 16'(want.game_frame_request),
                             16'(rsp_data.game_frame_request));
               compare_field("load_attempted", 16'(want.load_attempted),
                             16'(rsp_data.load_attempted));
               compare_field("args_accepted", 16'(want.args_accepted),
                             16'(rsp_data.args_accepted));
               compare_field("forward_actions", 16'(want.forward_actions),
                             16'(rsp_data.forward_actions));
               compare_field("unknown_sender", 16'(want.unknown_sender),
                             16'(rsp_data.unknown_sender));
               compare_field("phase", 16'(want.phase), 16'(rsp_data.phase));
               compare_field("in_error", 16'(want.in_error), 16'(rsp_data.in_error));
            end
         end
         if (req_valid && req_ready) begin
            outcome_q.push_back(advance_session(req_data));
            owed++;
         end
      end
   end

endmodule

// ===== bench/tb_lockstep_startup_handshake_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lockstep_startup_handshake_core
// Walks the handshake core once through start-up with directed events, then
// runs random events under several register settings, with random idling on
// the request and result sides. Prediction and compare live in the checker.
// ----------------------------------------------------------------------------
module tb_lockstep_startup_handshake_core;
   import lsh_pkg::*;

   localparam int         CYCLE_LIMIT       = 400000;
   localparam int         ITEMS_PER_SETTING = 360;
   localparam logic [1:0] ACT_NONE          = 2'd3;
   localparam logic [2:0] KIND_UNUSED       = 3'd7;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   rsp_type              rsp_data;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_wdata;
   int                   fail_count;
   int                   outstanding;
   int                   cycle_count = 0;
   bit                   no_idle     = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   lockstep_startup_handshake_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   lsh_session_checker u_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   function automatic int pick_wait();
      return no_idle ? 0 : $urandom_range(0, 19);
   endfunction

   function automatic req_type make_event(input logic [1:0] act, input logic ok,
                                          input logic [2:0] kind,
                                          input logic [SLOT_W-1:0] who,
                                          input logic [LEN_W-1:0] len);
      req_type ev;
      ev.action   = act;
      ev.load_ok  = ok;
      ev.msg_kind = kind;
      ev.sender   = who;
      ev.msg_len  = len;
      return ev;
   endfunction

   // mostly polls and messages; the held slot stays unloaded while spared
   function automatic req_type random_event(input logic [SLOT_W-1:0] held,
                                            input bit spare_held);
      req_type     ev;
      int unsigned pick;
      ev.load_ok = 1'($urandom);
      ev.sender  = SLOT_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 15)      ev.action = ACT_LOAD;
      else if (pick < 45) ev.action = ACT_POLL;
      else if (pick < 95) ev.action = ACT_MSG;
      else                ev.action = ACT_NONE;
      pick = $urandom_range(0, 99);
      if (pick < 15)      ev.msg_kind = KIND_START_COND;
      else if (pick < 45) ev.msg_kind = KIND_LOADED;
      else if (pick < 80) ev.msg_kind = KIND_ACTIONS;
      else if (pick < 86) ev.msg_kind = KIND_LOAD_ERR;
      else if (pick < 92) ev.msg_kind = KIND_OTHER;
      else                ev.msg_kind = 3'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 10)      ev.msg_len = '0;
      else if (pick < 25) ev.msg_len = 16'd1;
      else if (pick < 75) ev.msg_len = LEN_W'($urandom_range(2, 15));
      else                ev.msg_len = LEN_W'($urandom);
      if (spare_held && ev.msg_kind == KIND_LOADED && ev.sender == held)
         ev.sender = held + 1'b1;
      return ev;
   endfunction

   task automatic send_event(input req_type ev);
      int gap;
      gap = pick_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= ev;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic program_session(input logic host, input logic [SLOT_W-1:0] slot,
                                  input logic [NUM_SLOTS-1:0] group);
      logic [CSR_DAT_W-1:0] value [0:2];
      value[CSR_IS_HOST]    = CSR_DAT_W'(host);
      value[CSR_LOCAL_SLOT] = CSR_DAT_W'(slot);
      value[CSR_PART_MASK]  = CSR_DAT_W'(group);
      for (int i = CSR_IS_HOST; i <= CSR_PART_MASK; i++) begin
         csr_valid <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= value[i];
         do @(posedge clock); while (!csr_ready);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   // hold requests until every result is back, then let the pipe drain
   task automatic settle();
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   initial begin
      logic [SLOT_W-1:0]    own;
      logic [SLOT_W-1:0]    peer;
      logic [SLOT_W-1:0]    stranger;
      logic [NUM_SLOTS-1:0] group;
      bit                   as_host;
      bit                   load_fails;
      bit                   quick_start;
      bit                   linger;
      int                   run_left;

      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      run_left  = 0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      as_host     = 1'($urandom);
      load_fails  = ($urandom_range(0, 3) == 0);
      quick_start = ($urandom_range(0, 7) == 0);
      linger      = 1'($urandom);
      own  = SLOT_W'($urandom);
      peer = own + SLOT_W'($urandom_range(1, NUM_SLOTS - 1));
      do stranger = SLOT_W'($urandom); while (stranger == own || stranger == peer);
      group = (NUM_SLOTS'(1) << own) | (NUM_SLOTS'(1) << peer);
      group = group | (NUM_SLOTS'(1) << $urandom_range(0, NUM_SLOTS - 1));
      group = group & ~(NUM_SLOTS'(1) << stranger);
      program_session(as_host, own, group);

      // noise before the first poll
      send_event(make_event(ACT_LOAD, quick_start, KIND_OTHER, peer, '0));
      send_event(make_event(ACT_MSG, 1'b1, KIND_LOADED, peer, '0));
      send_event(make_event(ACT_MSG, 1'b0, KIND_START_COND, peer, 16'd1));
      send_event(make_event(ACT_NONE, 1'b1, KIND_ACTIONS, '1, '1));
      send_event(make_event(ACT_MSG, 1'b1, KIND_OTHER, '1, '1));
      send_event(make_event(ACT_MSG, 1'b0, KIND_UNUSED, '0, 16'h8000));
      send_event(make_event(ACT_MSG, 1'b1, KIND_LOAD_ERR, own, 16'd3));
      // start-up poll picks the host or client path
      send_event(make_event(ACT_POLL, 1'b0, KIND_LOAD_ERR, '0, '0));
      send_event(make_event(ACT_MSG, 1'b0, KIND_START_COND, own, 16'd1));
      send_event(make_event(ACT_MSG, 1'b0, KIND_START_COND, peer, 16'd9));
      if (as_host) send_event(make_event(ACT_POLL, 1'b1, KIND_START_COND, peer, 16'd2));
      send_event(make_event(ACT_LOAD, 1'b1, KIND_LOADED, own, 16'd4));
      send_event(make_event(ACT_POLL, !load_fails, KIND_ACTIONS, peer, 16'd7));
      send_event(make_event(ACT_POLL, 1'b0, KIND_LOADED, '0, '1));
      send_event(make_event(ACT_POLL, 1'b1, KIND_OTHER, '1, '0));
      send_event(make_event(ACT_MSG, 1'b0, KIND_LOADED, stranger, 16'd1));
      send_event(make_event(ACT_MSG, 1'b1, KIND_LOADED, own, 16'd2));
      send_event(make_event(ACT_MSG, 1'b0, KIND_ACTIONS, peer, 16'd5));
      if (!linger) begin
         for (int s = 0; s < NUM_SLOTS; s++) begin
            if (group[s] && SLOT_W'(s) != own)
               send_event(make_event(ACT_MSG, 1'b1, KIND_LOADED, SLOT_W'(s), 16'd1));
         end
         send_event(make_event(ACT_MSG, 1'b0, KIND_LOADED, stranger, 16'd1));
         send_event(make_event(ACT_POLL, 1'b1, KIND_OTHER, own, '0));
         send_event(make_event(ACT_MSG, 1'b0, KIND_ACTIONS, peer, 16'd1));
         send_event(make_event(ACT_MSG, 1'b1, KIND_ACTIONS, peer, 16'd2));
         send_event(make_event(ACT_MSG, 1'b0, KIND_ACTIONS, '1, '1));
         send_event(make_event(ACT_MSG, 1'b1, KIND_ACTIONS, '0, '0));
      end

      // the stranger slot stays unloaded until the last setting
      for (int setting = 0; setting < 5; setting++) begin
         settle();
         case (setting)
            0: program_session(1'b1, '1, NUM_SLOTS'($urandom) | (NUM_SLOTS'(1) << stranger));
            1: program_session(1'b0, '0, '0);
            4: program_session(1'($urandom), SLOT_W'($urandom), '1);
            default: program_session(1'($urandom), SLOT_W'($urandom),
                                     NUM_SLOTS'($urandom) | (NUM_SLOTS'(1) << stranger));
         endcase
         for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
            if (run_left == 0) begin
               no_idle  = ($urandom_range(0, 3) == 0);
               run_left = $urandom_range(20, 80);
            end
            run_left--;
            send_event(random_event(stranger, setting < 4));
         end
      end

      settle();
      if (fail_count == 0) $display("tb_lockstep_startup_handshake_core: clean");
      else $display("tb_lockstep_startup_handshake_core: errors");
      $finish;
   end

   initial begin
      int stall;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         stall = pick_wait();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_lockstep_startup_handshake_core: errors");
         $finish;
      end
   end

endmodule
